[rtl/core/pulse_width_frame_decoder_core_macros.svh]
// assertion helpers for the frame decoder checker
`ifndef PULSE_WIDTH_FRAME_DECODER_CORE_MACROS_SVH
`define PULSE_WIDTH_FRAME_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define PWFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwfd same-cycle check failed");

// next-cycle implication
`define PWFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwfd next-cycle check failed");

`endif

[rtl/core/pwfd_pkg.sv]
`default_nettype none

package pwfd_pkg;

    localparam int DATA_BITS = 8;
    localparam int TICK_W    = 15;
    localparam int BYTE_W    = 8;
    localparam int POS_W     = $clog2(DATA_BITS + 1);
    localparam int CFG_IDX_W = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MAX  = 2'd3;

    localparam logic [TICK_W-1:0] RST_SHORT_MIN = 15'd27;
    localparam logic [TICK_W-1:0] RST_SHORT_MAX = 15'd33;
    localparam logic [TICK_W-1:0] RST_LONG_MIN  = 15'd67;
    localparam logic [TICK_W-1:0] RST_LONG_MAX  = 15'd73;

    localparam logic [BYTE_W-1:0] BYTE_MSB = 8'h80;

    // classified symbol passed from front to back
    typedef struct packed {
        logic frame_start;
        logic is_zero;
        logic is_one;
        logic stop_ok;
    } t_sym;

endpackage

`default_nettype wire

[rtl/core/pwfd_front.sv]
`default_nettype none

module pwfd_front import pwfd_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TICK_W-1:0]    i_cfg_data,
    input  wire logic                 i_frame_start,
    input  wire logic                 i_first_level,
    input  wire logic [TICK_W-1:0]    i_first_ticks,
    input  wire logic                 i_second_level,
    input  wire logic [TICK_W-1:0]    i_second_ticks,
    output t_sym                      o_sym
);

    logic [TICK_W-1:0] r_short_min;
    logic [TICK_W-1:0] r_short_max;
    logic [TICK_W-1:0] r_long_min;
    logic [TICK_W-1:0] r_long_max;

    logic shape_ok;
    logic short0;
    logic short1;
    logic long0;
    logic long1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_min <= RST_SHORT_MIN;
            r_short_max <= RST_SHORT_MAX;
            r_long_min  <= RST_LONG_MIN;
            r_long_max  <= RST_LONG_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SHORT_MIN: r_short_min <= i_cfg_data;
                CFG_SHORT_MAX: r_short_max <= i_cfg_data;
                CFG_LONG_MIN:  r_long_min  <= i_cfg_data;
                CFG_LONG_MAX:  r_long_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        shape_ok = i_first_level && !i_second_level;
        short0   = (i_first_ticks >= r_short_min) && (i_first_ticks <= r_short_max);
        short1   = (i_second_ticks >= r_short_min) && (i_second_ticks <= r_short_max);
        long0    = (i_first_ticks >= r_long_min) && (i_first_ticks <= r_long_max);
        long1    = (i_second_ticks >= r_long_min) && (i_second_ticks <= r_long_max);

        o_sym.frame_start = i_frame_start;
        o_sym.is_zero     = shape_ok && short0 && long1;
        o_sym.is_one      = shape_ok && long0 && short1;
        o_sym.stop_ok     = shape_ok && short0 && (i_second_ticks == '0);
    end

endmodule

`default_nettype wire

[rtl/core/pwfd_queue.sv]
`default_nettype none

module pwfd_queue import pwfd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_sym i_item,
    output logic      o_full,
    output logic      o_nonempty,
    input  wire logic i_pop,
    output t_sym      o_item
);

    t_sym            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    logic            do_push;
    logic            do_pop;
    logic [Q_AW-1:0] n_wr_ptr;
    logic [Q_AW-1:0] n_rd_ptr;

    assign o_full     = (r_count == Q_CW'(Q_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/pwfd_back.sv]
`default_nettype none

module pwfd_back import pwfd_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_sym_avail,
    input  wire t_sym               i_sym,
    output logic                    o_sym_take,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [BYTE_W-1:0]       o_byte_out,
    output logic                    o_frame_valid
);

    logic [POS_W-1:0]  r_pos;
    logic [BYTE_W-1:0] r_acc;
    logic              r_err;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_fvalid;

    logic [POS_W-1:0]  eff_pos;
    logic [BYTE_W-1:0] eff_acc;
    logic              eff_err;
    logic              is_stop;
    logic              out_free;
    logic [POS_W-1:0]  n_pos;
    logic [BYTE_W-1:0] n_acc;
    logic              n_err;

    always_comb begin
        eff_pos  = i_sym.frame_start ? '0 : r_pos;
        eff_acc  = i_sym.frame_start ? '0 : r_acc;
        eff_err  = i_sym.frame_start ? 1'b0 : r_err;
        is_stop  = !(eff_pos < POS_W'(DATA_BITS));
        out_free = !r_valid || !i_stall;

        o_sym_take = i_sym_avail && (!is_stop || out_free);

        n_pos = POS_W'(eff_pos + 1'b1);
        n_acc = eff_acc;
        n_err = eff_err;
        if (is_stop) begin
            n_pos = '0;
            n_acc = '0;
            n_err = 1'b0;
        end else if (!eff_err) begin
            if (i_sym.is_zero) begin
                n_acc = eff_acc;
            end else if (i_sym.is_one) begin
                // shifting past the byte adds nothing for positions above it
                n_acc = eff_acc | (BYTE_MSB >> eff_pos);
            end else begin
                n_err = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_acc   <= '0;
            r_err   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            if (o_sym_take) begin
                r_pos <= n_pos;
                r_acc <= n_acc;
                r_err <= n_err;
                if (is_stop) begin
                    r_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_sym_take && is_stop) begin
            r_byte   <= eff_acc;
            r_fvalid <= !eff_err && i_sym.stop_ok;
        end
    end

    assign o_valid       = r_valid;
    assign o_byte_out    = r_byte;
    assign o_frame_valid = r_fvalid;

endmodule

`default_nettype wire

[rtl/core/pulse_width_frame_decoder_core.sv]
// Pulse-width frame decoder. Each input beat is one symbol (two line levels with
// tick durations); eight data symbols and one stop symbol form a frame, and the
// stop symbol yields one output beat with the byte (MSB first) and frame_valid.
// i_frame_start restarts the frame at the current symbol. One symbol is taken
// per clock while o_stall is low: the front compares durations against the four
// tick-range registers in the accepting cycle and writes the result into a
// two-entry queue; the back pops one entry per cycle (a held output beat blocks a
// stop symbol) into the frame state and the registered output beat (o_valid).
// Write the range registers only while no frame is in flight.
`default_nettype none

module pulse_width_frame_decoder_core import pwfd_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TICK_W-1:0]    i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_frame_start,
    input  wire logic                 i_first_level,
    input  wire logic [TICK_W-1:0]    i_first_ticks,
    input  wire logic                 i_second_level,
    input  wire logic [TICK_W-1:0]    i_second_ticks,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [BYTE_W-1:0]         o_byte_out,
    output logic                      o_frame_valid
);

    t_sym front_sym;
    t_sym q_sym;
    logic q_full;
    logic q_nonempty;
    logic q_pop;

    pwfd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_frame_start  (i_frame_start),
        .i_first_level  (i_first_level),
        .i_first_ticks  (i_first_ticks),
        .i_second_level (i_second_level),
        .i_second_ticks (i_second_ticks),
        .o_sym          (front_sym)
    );

    pwfd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_valid),
        .i_item     (front_sym),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .i_pop      (q_pop),
        .o_item     (q_sym)
    );

    pwfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sym_avail   (q_nonempty),
        .i_sym         (q_sym),
        .o_sym_take    (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_byte_out    (o_byte_out),
        .o_frame_valid (o_frame_valid)
    );

    assign o_stall = q_full;

endmodule

`default_nettype wire

[rtl/core/pwfd_checker.sv]
`default_nettype none

`include "pulse_width_frame_decoder_core_macros.svh"

module pwfd_checker import pwfd_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_valid,
    input wire logic                 o_stall,
    input wire logic                 o_valid,
    input wire logic                 i_stall,
    input wire logic [BYTE_W-1:0]    o_byte_out,
    input wire logic                 o_frame_valid
);

    logic [BYTE_W:0] out_beat;

    assign out_beat = {o_byte_out, o_frame_valid};

    // a held output beat keeps its payload
    `PWFD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_beat))

    // the queue only fills through an accepted input beat
    `PWFD_ASSERT_IMP(a_stall_rise, i_clk, i_rst_n, $rose(o_stall), $past(i_valid && !o_stall))

    // a free output side drains the queue below full by the next cycle
    `PWFD_ASSERT_IMP(a_drain, i_clk, i_rst_n, $past(!i_stall), !o_stall)

endmodule

bind pulse_width_frame_decoder_core pwfd_checker u_pwfd_checker (.*);

`default_nettype wire

[test/tb_pulse_width_frame_decoder_core.sv]
`default_nettype none

typedef struct packed {
    logic                          frame_start;
    logic                          first_level;
    logic [pwfd_pkg::TICK_W-1:0]   first_ticks;
    logic                          second_level;
    logic [pwfd_pkg::TICK_W-1:0]   second_ticks;
} pulse_sym_t;

typedef struct packed {
    logic [pwfd_pkg::BYTE_W-1:0] data_byte;
    logic                        frame_ok;
} frame_result_t;

class frame_scoreboard;
    logic [pwfd_pkg::TICK_W-1:0] short_lo;
    logic [pwfd_pkg::TICK_W-1:0] short_hi;
    logic [pwfd_pkg::TICK_W-1:0] long_lo;
    logic [pwfd_pkg::TICK_W-1:0] long_hi;
    int                          position;
    logic [pwfd_pkg::BYTE_W-1:0] bits_so_far;
    bit                          bad_symbol_seen;
    frame_result_t               pending[$];
    int                          failures;

    function new();
        short_lo = pwfd_pkg::RST_SHORT_MIN;
        short_hi = pwfd_pkg::RST_SHORT_MAX;
        long_lo  = pwfd_pkg::RST_LONG_MIN;
        long_hi  = pwfd_pkg::RST_LONG_MAX;
        failures = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        position        = 0;
        bits_so_far     = '0;
        bad_symbol_seen = 1'b0;
    endfunction

    function void set_range(logic [pwfd_pkg::CFG_IDX_W-1:0] idx,
                            logic [pwfd_pkg::TICK_W-1:0] val);
        case (idx)
            pwfd_pkg::CFG_SHORT_MIN: short_lo = val;
            pwfd_pkg::CFG_SHORT_MAX: short_hi = val;
            pwfd_pkg::CFG_LONG_MIN:  long_lo  = val;
            pwfd_pkg::CFG_LONG_MAX:  long_hi  = val;
            default: ;
        endcase
    endfunction

    function bit fits_short(logic [pwfd_pkg::TICK_W-1:0] d);
        return d >= short_lo && d <= short_hi;
    endfunction

    function bit fits_long(logic [pwfd_pkg::TICK_W-1:0] d);
        return d >= long_lo && d <= long_hi;
    endfunction

    function void flag(string msg);
        failures++;
        if (failures <= 10) $display("%s", msg);
    endfunction

    // one accepted symbol beat
    function void note_symbol(pulse_sym_t s);
        bit            shape_ok;
        frame_result_t r;
        shape_ok = s.first_level && !s.second_level;
        if (s.frame_start) clear_frame();
        if (position < pwfd_pkg::DATA_BITS) begin
            if (!bad_symbol_seen) begin
                if (shape_ok && fits_short(s.first_ticks) && fits_long(s.second_ticks)) begin
                    // zero bit, zero wins when ranges overlap
                end else if (shape_ok && fits_long(s.first_ticks)
                             && fits_short(s.second_ticks)) begin
                    if (position < 8) bits_so_far |= pwfd_pkg::BYTE_MSB >> position;
                end else begin
                    bad_symbol_seen = 1'b1;
                end
            end
            position++;
        end else begin
            r.data_byte = bits_so_far;
            r.frame_ok  = !bad_symbol_seen && shape_ok && fits_short(s.first_ticks)
                          && s.second_ticks == '0;
            pending.push_back(r);
            clear_frame();
        end
    endfunction

    function void check_result(logic [pwfd_pkg::BYTE_W-1:0] b, logic ok);
        frame_result_t want;
        if (pending.size() == 0) begin
            flag($sformatf("unexpected frame beat: byte %02h frame_valid %0b", b, ok));
            return;
        end
        want = pending.pop_front();
        if (b !== want.data_byte)
            flag($sformatf("byte_out mismatch: expected %02h got %02h", want.data_byte, b));
        if (ok !== want.frame_ok)
            flag($sformatf("frame_valid mismatch: expected %0b got %0b", want.frame_ok, ok));
    endfunction

    function void close();
        if (pending.size() != 0)
            flag($sformatf("%0d decoded frames never arrived", pending.size()));
    endfunction
endclass

module tb_pulse_width_frame_decoder_core;
    import pwfd_pkg::*;

    localparam int          IDLE_LIMIT     = 1000;
    localparam int          ITEMS_PER_SET  = 65;
    localparam logic [7:0]  PATTERN_A      = 8'hA5;
    localparam logic [7:0]  PATTERN_B      = 8'h3C;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx      = '0;
    logic [TICK_W-1:0]    i_cfg_data     = '0;
    logic                 i_valid        = 1'b0;
    logic                 o_stall;
    logic                 i_frame_start  = 1'b0;
    logic                 i_first_level  = 1'b0;
    logic [TICK_W-1:0]    i_first_ticks  = '0;
    logic                 i_second_level = 1'b0;
    logic [TICK_W-1:0]    i_second_ticks = '0;
    logic                 o_valid;
    logic                 i_stall        = 1'b0;
    logic [BYTE_W-1:0]    o_byte_out;
    logic                 o_frame_valid;

    frame_scoreboard sb;
    int burst_left  = 0;
    int items_sent  = 0;
    int idle_cycles = 0;
    int stall_mode  = 0;
    int mode_left   = 0;
    int stall_hold  = 0;

    logic [TICK_W-1:0] range_tab [5][4] = '{
        '{15'd20,   15'd60,    15'd40,    15'd90},
        '{15'd50,   15'd10,    15'd100,   15'd200},
        '{15'd0,    15'd0,     15'd32767, 15'd32767},
        '{15'd0,    15'd32767, 15'd0,     15'd32767},
        '{15'd1000, 15'd1023,  15'd21845, 15'd27306}
    };

    pulse_width_frame_decoder_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_frame_start  (i_frame_start),
        .i_first_level  (i_first_level),
        .i_first_ticks  (i_first_ticks),
        .i_second_level (i_second_level),
        .i_second_ticks (i_second_ticks),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_out     (o_byte_out),
        .o_frame_valid  (o_frame_valid)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // mostly inside the range, sometimes on or just past an edge
    function automatic logic [TICK_W-1:0] pick_dur(logic [TICK_W-1:0] lo,
                                                   logic [TICK_W-1:0] hi);
        int r;
        r = $urandom_range(79);
        if (r == 0) return lo - 1'b1;
        if (r == 1) return hi + 1'b1;
        if (r < 12) return lo;
        if (r < 22) return hi;
        return TICK_W'($urandom_range(hi, lo));
    endfunction

    function automatic pulse_sym_t make_sym(logic fs, logic l0, logic [TICK_W-1:0] t0,
                                            logic l1, logic [TICK_W-1:0] t1);
        pulse_sym_t s;
        s.frame_start  = fs;
        s.first_level  = l0;
        s.first_ticks  = t0;
        s.second_level = l1;
        s.second_ticks = t1;
        return s;
    endfunction

    function automatic pulse_sym_t bit_sym(logic fs, logic one);
        if (one)
            return make_sym(fs, 1'b1, pick_dur(sb.long_lo, sb.long_hi),
                            1'b0, pick_dur(sb.short_lo, sb.short_hi));
        return make_sym(fs, 1'b1, pick_dur(sb.short_lo, sb.short_hi),
                        1'b0, pick_dur(sb.long_lo, sb.long_hi));
    endfunction

    function automatic pulse_sym_t stop_sym(logic [TICK_W-1:0] low_ticks);
        return make_sym(1'b0, 1'b1, pick_dur(sb.short_lo, sb.short_hi), 1'b0, low_ticks);
    endfunction

    function automatic pulse_sym_t noise_sym(logic fs);
        return make_sym(fs, 1'($urandom), TICK_W'($urandom), 1'($urandom), TICK_W'($urandom));
    endfunction

    task automatic issue(pulse_sym_t s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_frame_start  <= s.frame_start;
        i_first_level  <= s.first_level;
        i_first_ticks  <= s.first_ticks;
        i_second_level <= s.second_level;
        i_second_ticks <= s.second_ticks;
        i_valid        <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_symbol(s);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_frame();
        logic fs;
        int   r;
        fs = 1'($urandom);
        for (int k = 0; k < DATA_BITS; k++) begin
            r = $urandom_range(99);
            if (r < 4) issue(noise_sym(1'b0));
            else issue(bit_sym((k == 0 && fs) || r == 99, 1'($urandom)));
        end
        r = $urandom_range(9);
        if (r < 7) issue(stop_sym('0));
        else if (r == 7) issue(stop_sym(TICK_W'($urandom_range(32767, 1))));
        else if (r == 8) issue(noise_sym(1'b0));
        else issue(make_sym(1'b0, 1'b0, pick_dur(sb.short_lo, sb.short_hi), 1'b1, '0));
        if ($urandom_range(5) == 0)
            repeat ($urandom_range(3, 1)) issue(noise_sym($urandom_range(7) == 0));
    endtask

    // finish the open frame, then let the pipeline empty
    task automatic settle();
        while (sb.position != 0) issue(noise_sym(1'b0));
        i_valid    <= 1'b0;
        burst_left  = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_range(idx, val);
    endtask

    task automatic load_ranges(logic [TICK_W-1:0] s_lo, logic [TICK_W-1:0] s_hi,
                               logic [TICK_W-1:0] l_lo, logic [TICK_W-1:0] l_hi);
        settle();
        put_reg(CFG_SHORT_MIN, s_lo);
        put_reg(CFG_SHORT_MAX, s_hi);
        put_reg(CFG_LONG_MIN, l_lo);
        put_reg(CFG_LONG_MAX, l_hi);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int                target;
        logic [TICK_W-1:0] s_lo;
        logic [TICK_W-1:0] l_lo;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // clean frame under reset ranges
        for (int k = 0; k < 8; k++) issue(bit_sym(k == 0, PATTERN_A[7-k]));
        issue(stop_sym('0));
        // bad shape at the third bit, then a restart that clears the error
        issue(bit_sym(1'b1, 1'b1));
        issue(bit_sym(1'b0, 1'b1));
        issue(make_sym(1'b0, 1'b0, '0, 1'b1, '1));
        for (int k = 0; k < 8; k++) issue(bit_sym(k == 0, PATTERN_B[7-k]));
        // stop with a nonzero low part
        issue(stop_sym(15'd1));

        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 5) begin
                load_ranges(range_tab[ph][0], range_tab[ph][1],
                            range_tab[ph][2], range_tab[ph][3]);
            end else begin
                s_lo = TICK_W'($urandom_range(2000));
                l_lo = TICK_W'($urandom_range(20000, 4000));
                load_ranges(s_lo, s_lo + TICK_W'($urandom_range(2000)),
                            l_lo, l_lo + TICK_W'($urandom_range(5000)));
            end
            target = items_sent + ITEMS_PER_SET;
            while (items_sent < target) send_frame();
        end

        settle();
        sb.close();
        if (sb.failures == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    // receiver back-pressure in one of four randomly chosen modes
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(3);
            mode_left  <= $urandom_range(150, 20);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(2) == 0);
            2: begin
                if (stall_hold == 0) begin
                    i_stall    <= !i_stall;
                    stall_hold <= i_stall ? $urandom_range(6, 1) : $urandom_range(40, 1);
                end else begin
                    stall_hold <= stall_hold - 1;
                end
            end
            default: i_stall <= ~i_stall;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_byte_out, o_frame_valid);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl/core
rtl/core/pwfd_pkg.sv
rtl/core/pwfd_front.sv
rtl/core/pwfd_queue.sv
rtl/core/pwfd_back.sv
rtl/core/pulse_width_frame_decoder_core.sv
rtl/core/pwfd_checker.sv
test/tb_pulse_width_frame_decoder_core.sv
